### rtl/core/sgma_pkg.sv
// ----------------------------------------------------------------------------
// sgma_pkg
// Shared types and constants of the sorted group max/average aggregator.
// ----------------------------------------------------------------------------
`default_nettype none

package sgma_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned SUM_W = 63;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned AVG_W = 31;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // One finished group, handed from the front to the divider.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] max;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } job_t;

  // Up to two jobs per accepted item; job1 only valid together with job0.
  typedef struct packed {
    logic vld0;
    logic vld1;
    job_t job0;
    job_t job1;
  } q_push_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

### rtl/core/sgma_front.sv
// ----------------------------------------------------------------------------
// sgma_front
// Accumulates max, sum and count of the open group; issues finished groups.
// ----------------------------------------------------------------------------
`default_nettype none

module sgma_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [sgma_pkg::KEY_W-1:0]  key,
  input  wire logic [sgma_pkg::VAL_W-1:0]  val,
  input  wire logic                        eos,
  output sgma_pkg::q_push_t                q_push
);

  logic                       open_r, open_nxt;
  logic [sgma_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [sgma_pkg::VAL_W-1:0] max_r, max_nxt;
  logic [sgma_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [sgma_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic           same;
  logic           old_vld;
  sgma_pkg::job_t old_job;
  sgma_pkg::job_t fold_job;

  always_comb begin
    same = open_r && (key == key_r);
    if (same) begin
      key_nxt = key_r;
      max_nxt = (val > max_r) ? val : max_r;
      if (cnt_r != sgma_pkg::CNT_MAX) begin
        sum_nxt = sum_r + {{(sgma_pkg::SUM_W - sgma_pkg::VAL_W){1'b0}}, val};
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        sum_nxt = sum_r;
        cnt_nxt = cnt_r;
      end
    end else begin
      key_nxt = key;
      max_nxt = val;
      sum_nxt = {{(sgma_pkg::SUM_W - sgma_pkg::VAL_W){1'b0}}, val};
      cnt_nxt = {{(sgma_pkg::CNT_W - 1){1'b0}}, 1'b1};
    end
    open_nxt = !eos;

    old_vld       = open_r && !same;
    old_job.key   = key_r;
    old_job.max   = max_r;
    old_job.sum   = sum_r;
    old_job.cnt   = cnt_r;
    old_job.last  = !eos;
    fold_job.key  = key_nxt;
    fold_job.max  = max_nxt;
    fold_job.sum  = sum_nxt;
    fold_job.cnt  = cnt_nxt;
    fold_job.last = 1'b1;

    // previous group first, then the flushed one on end of stream
    q_push.vld0 = accept && (old_vld || eos);
    q_push.vld1 = accept && old_vld && eos;
    q_push.job0 = old_vld ? old_job : fold_job;
    q_push.job1 = fold_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (accept) begin
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= key_nxt;
      max_r <= max_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sgma_queue.sv
// ----------------------------------------------------------------------------
// sgma_queue
// Small job queue between front and divider; takes up to two jobs a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sgma_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sgma_pkg::q_push_t q_push,
  input  wire logic              rd,
  output sgma_pkg::job_t         head,
  output logic                   empty,
  output logic                   no_room
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  sgma_pkg::job_t mem [DEPTH];

  logic [AW-1:0] wp_r, wp_nxt, wp1;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
    incr = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wp1     = incr(wp_r);
    wp_nxt  = q_push.vld1 ? incr(wp1) : (q_push.vld0 ? wp1 : wp_r);
    rp_nxt  = rd ? incr(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(q_push.vld0) + CW'(q_push.vld1) - CW'(rd);
    head    = mem[rp_r];
    empty   = (cnt_r == '0);
    // an item may bring two jobs
    no_room = ({1'b0, cnt_r} + (CW + 1)'(2)) > (CW + 1)'(DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.vld0) begin
      mem[wp_r] <= q_push.job0;
    end
    if (q_push.vld1) begin
      mem[wp1] <= q_push.job1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sgma_back.sv
// ----------------------------------------------------------------------------
// sgma_back
// Radix-2 divider for sum/count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgma_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sgma_pkg::job_t              head,
  input  wire logic                        q_empty,
  output logic                             q_rd,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [sgma_pkg::KEY_W-1:0]       key_out,
  output logic [sgma_pkg::VAL_W-1:0]       max_out,
  output logic [sgma_pkg::AVG_W-1:0]       avg_out,
  output logic                             last_out
);

  localparam int unsigned AVG_W = sgma_pkg::AVG_W;
  localparam int unsigned CNT_W = sgma_pkg::CNT_W;
  localparam int unsigned SW    = $clog2(AVG_W);
  localparam logic [SW-1:0] LAST_STEP = SW'(AVG_W - 1);

  sgma_pkg::bk_state_t state_r, state_nxt;

  logic [SW-1:0]              step_r, step_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [AVG_W-1:0]           quo_r, quo_nxt;
  logic [CNT_W-1:0]           div_r;
  logic [sgma_pkg::KEY_W-1:0] key_r;
  logic [sgma_pkg::VAL_W-1:0] max_r;
  logic                       last_r;
  logic                       load;
  logic                       out_vld_r, out_vld_nxt;
  logic                       out_load;
  logic [CNT_W:0]             trial;
  logic                       take;

  // quotient bits shift in where dividend bits shift out
  always_comb begin
    trial = {rem_r, quo_r[AVG_W-1]};
    take  = trial >= {1'b0, div_r};
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    load      = 1'b0;
    q_rd      = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      sgma_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_rd      = 1'b1;
          load      = 1'b1;
          // average < 2^31, so the upper dividend bits are below the count
          rem_nxt   = head.sum[sgma_pkg::SUM_W-1:AVG_W];
          quo_nxt   = head.sum[AVG_W-1:0];
          step_nxt  = '0;
          state_nxt = sgma_pkg::BK_DIV;
        end
      end
      sgma_pkg::BK_DIV: begin
        rem_nxt  = take ? CNT_W'(trial - {1'b0, div_r}) : trial[CNT_W-1:0];
        quo_nxt  = {quo_r[AVG_W-2:0], take};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = sgma_pkg::BK_DONE;
        end
      end
      sgma_pkg::BK_DONE: begin
        if (!out_vld_r || pop) begin
          out_load  = 1'b1;
          state_nxt = sgma_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = sgma_pkg::BK_IDLE;
      end
    endcase
    out_vld_nxt = out_load ? 1'b1 : (pop ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sgma_pkg::BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    if (load) begin
      div_r  <= head.cnt;
      key_r  <= head.key;
      max_r  <= head.max;
      last_r <= head.last;
    end
    if (out_load) begin
      key_out  <= key_r;
      max_out  <= max_r;
      avg_out  <= (div_r == '0) ? '0 : quo_r;
      last_out <= last_r;
    end
  end

  assign empty = !out_vld_r;

endmodule

`default_nettype wire

### rtl/core/sorted_group_max_average.sv
// ----------------------------------------------------------------------------
// sorted_group_max_average
// Group-by over key-sorted records: emits key, max and average per group.
// ----------------------------------------------------------------------------
//  channel  | handshake     | payload
//  ---------+---------------+-------------------------------------------------
//  input    | push / full   | in_record_key, in_record_value, in_end_of_stream
//  result   | empty / pop   | out_group_key_out, out_group_max_out,
//           |               | out_group_average_out, out_run_last
//
//  The front folds one record per cycle into the open group while full is low.
//  Each finished group passes through the back end as load, 31 divider
//  steps and hand-off; the radix-2 divider sets the per-group rate.
//  The job queue (QUEUE_DEPTH entries) lets records stream on while groups
//  divide; full rises when fewer than two entries are free.
//  Synchronous reset clears the open group, the queue and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_group_max_average #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [sgma_pkg::KEY_W-1:0] in_record_key,
  input  wire logic [sgma_pkg::VAL_W-1:0] in_record_value,
  input  wire logic                       in_end_of_stream,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [sgma_pkg::KEY_W-1:0]      out_group_key_out,
  output logic [sgma_pkg::VAL_W-1:0]      out_group_max_out,
  output logic [sgma_pkg::AVG_W-1:0]      out_group_average_out,
  output logic                            out_run_last
);

  sgma_pkg::q_push_t q_push;
  sgma_pkg::job_t    q_head;
  logic              q_empty;
  logic              q_rd;
  logic              accept;

  assign accept = push && !full;

  sgma_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .key    (in_record_key),
    .val    (in_record_value),
    .eos    (in_end_of_stream),
    .q_push (q_push)
  );

  sgma_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .rd      (q_rd),
    .head    (q_head),
    .empty   (q_empty),
    .no_room (full)
  );

  sgma_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .key_out  (out_group_key_out),
    .max_out  (out_group_max_out),
    .avg_out  (out_group_average_out),
    .last_out (out_run_last)
  );

endmodule

`default_nettype wire

### rtl/core/sgma_checker.sv
// ----------------------------------------------------------------------------
// sgma_checker
// Port-level checks of the group aggregator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgma_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       full,
  input wire logic                       empty,
  input wire logic                       pop,
  input wire logic [sgma_pkg::KEY_W-1:0] out_group_key_out,
  input wire logic [sgma_pkg::VAL_W-1:0] out_group_max_out,
  input wire logic [sgma_pkg::AVG_W-1:0] out_group_average_out,
  input wire logic                       out_run_last
);

  // reset leaves no result and room for items
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("full after reset");

  // an average never exceeds the group maximum
  a_avg_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_group_average_out <= out_group_max_out))
    else $error("average above maximum");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_group_key_out)
      && $stable(out_group_max_out) && $stable(out_group_average_out)
      && $stable(out_run_last)))
    else $error("waiting result changed");

endmodule

bind sorted_group_max_average sgma_checker u_sgma_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .full                  (full),
  .empty                 (empty),
  .pop                   (pop),
  .out_group_key_out     (out_group_key_out),
  .out_group_max_out     (out_group_max_out),
  .out_group_average_out (out_group_average_out),
  .out_run_last          (out_run_last)
);

`default_nettype wire

### test/tb_sorted_group_max_average.sv
// ----------------------------------------------------------------------------
// tb_sorted_group_max_average
// Self-checking bench: streams key-sorted records through the group
// aggregator and compares every finished group with a local prediction.
// A directed table covers key 0, full-scale keys and values, truncated
// averages, a key change together with end of stream and a restart after it.
// Random traffic follows: mostly well-formed runs with random content, plus
// unsorted noise. Both sides idle at random, the receiver holds off for a
// long stretch, and the sender drains once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_group_max_average;

  localparam int unsigned KEY_W = sgma_pkg::KEY_W;
  localparam int unsigned VAL_W = sgma_pkg::VAL_W;
  localparam int unsigned AVG_W = sgma_pkg::AVG_W;
  localparam int unsigned SUM_W = sgma_pkg::SUM_W;
  localparam int unsigned CNT_W = sgma_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = sgma_pkg::CNT_MAX;

  localparam int unsigned N_RANDOM   = 950;
  localparam int unsigned CYCLE_CAP  = 500000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned DRAIN_WAIT = 100;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;
  localparam logic [VAL_W-1:0] VAL_TOP = '1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] max;
    logic [AVG_W-1:0] avg;
    logic             last;
  } grp_result_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             eos;
    logic             typed;
    grp_result_t      want;
  } dir_row_t;

  localparam int unsigned NDIR = 21;
  localparam grp_result_t NO_WANT = '0;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [KEY_W-1:0]       in_record_key = '0;
  logic [VAL_W-1:0]       in_record_value = '0;
  logic                   in_end_of_stream = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [KEY_W-1:0]       out_group_key_out;
  logic [VAL_W-1:0]       out_group_max_out;
  logic [AVG_W-1:0]       out_group_average_out;
  logic                   out_run_last;

  sorted_group_max_average dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_record_key        (in_record_key),
    .in_record_value      (in_record_value),
    .in_end_of_stream     (in_end_of_stream),
    .empty                (empty),
    .pop                  (pop),
    .out_group_key_out    (out_group_key_out),
    .out_group_max_out    (out_group_max_out),
    .out_group_average_out(out_group_average_out),
    .out_run_last         (out_run_last)
  );

  // Directed records; typed rows carry the one group they close.
  dir_row_t dir_tab [NDIR] = '{
    '{'0, '0, 1'b1, 1'b1, '{'0, '0, '0, 1'b1}},
    '{KEY_TOP, VAL_TOP, 1'b1, 1'b1, '{KEY_TOP, VAL_TOP, VAL_TOP, 1'b1}},
    '{31'd5, 31'd10, 1'b0, 1'b0, NO_WANT},
    '{31'd5, 31'd3, 1'b0, 1'b0, NO_WANT},
    '{31'd5, VAL_TOP, 1'b0, 1'b0, NO_WANT},
    '{31'd6, 31'd1, 1'b0, 1'b0, NO_WANT},
    '{31'd6, 31'd2, 1'b0, 1'b0, NO_WANT},
    '{31'd7, 31'd0, 1'b1, 1'b0, NO_WANT},
    '{31'd7, 31'd9, 1'b0, 1'b0, NO_WANT},
    '{31'd7, 31'd9, 1'b1, 1'b1, '{31'd7, 31'd9, 31'd9, 1'b1}},
    '{31'd100, 31'd1, 1'b0, 1'b0, NO_WANT},
    '{31'd100, 31'd2, 1'b0, 1'b0, NO_WANT},
    '{KEY_TOP, VAL_TOP, 1'b0, 1'b0, NO_WANT},
    '{KEY_TOP, VAL_TOP, 1'b0, 1'b0, NO_WANT},
    '{KEY_TOP, 31'h7FFF_FFFE, 1'b0, 1'b0, NO_WANT},
    '{'0, '0, 1'b0, 1'b0, NO_WANT},
    '{'0, 31'd7, 1'b0, 1'b0, NO_WANT},
    '{31'h2AAA_AAAA, 31'h5555_5555, 1'b0, 1'b0, NO_WANT},
    '{31'h5555_5555, 31'h2AAA_AAAA, 1'b1, 1'b0, NO_WANT},
    '{31'h5555_5555, 31'h0000_0001, 1'b0, 1'b0, NO_WANT},
    '{31'h5555_5556, 31'h0000_0003, 1'b1, 1'b0, NO_WANT}
  };

  // Group state as the block should hold it
  logic             grp_open;
  logic [KEY_W-1:0] grp_key;
  logic [VAL_W-1:0] grp_max;
  logic [SUM_W-1:0] grp_sum;
  logic [CNT_W-1:0] grp_cnt;

  grp_result_t pending_groups[$];
  grp_result_t just_closed[$];

  int unsigned n_items, n_results, n_errors, n_eos, n_double, n_cycles;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic grp_result_t close_group(logic last);
    grp_result_t r;
    logic [SUM_W-1:0] q;
    q = (grp_cnt == '0) ? '0 : grp_sum / grp_cnt;
    r.key  = grp_key;
    r.max  = grp_max;
    r.avg  = q[AVG_W-1:0];
    r.last = last;
    return r;
  endfunction

  task automatic clear_group();
    grp_open = 1'b0;
    grp_key  = '0;
    grp_max  = '0;
    grp_sum  = '0;
    grp_cnt  = '0;
  endtask

  // Folds one record into the open group; closed groups land in just_closed.
  task automatic fold_record(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v, logic eos);
    just_closed.delete();
    if (grp_open && k == grp_key) begin
      if (v > grp_max) grp_max = v;
      if (grp_cnt != CNT_MAX) begin
        grp_sum = grp_sum + SUM_W'(v);
        grp_cnt = grp_cnt + 1'b1;
      end
    end else begin
      if (grp_open) just_closed.push_back(close_group(!eos));
      grp_open = 1'b1;
      grp_key  = k;
      grp_max  = v;
      grp_sum  = SUM_W'(v);
      grp_cnt  = CNT_W'(1);
    end
    if (eos) begin
      just_closed.push_back(close_group(1'b1));
      clear_group();
      n_eos++;
    end
    if (just_closed.size() == 2) n_double++;
  endtask

  task automatic send_item(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v, logic eos,
                           logic typed, grp_result_t want);
    while (!calm && $urandom_range(99) < 21) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    in_record_key    <= k;
    in_record_value  <= v;
    in_end_of_stream <= eos;
    do @(posedge clk); while (full);
    n_items++;
    fold_record(k, v, eos);
    if (typed) pending_groups.push_back(want);
    else foreach (just_closed[i]) pending_groups.push_back(just_closed[i]);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return VAL_TOP;
      2, 3:    return VAL_W'($urandom_range(255));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // One run of a key with random content, or a single unsorted noise record
  task automatic random_group(inout logic [KEY_W-1:0] last_key);
    logic [KEY_W-1:0] k;
    int unsigned      len;
    bit               ends;
    if ($urandom_range(9) == 0) begin
      send_item(KEY_W'($urandom), pick_value(), ($urandom_range(7) == 0), 1'b0, NO_WANT);
      return;
    end
    case ($urandom_range(9))
      0:       k = '0;
      1:       k = KEY_TOP;
      2, 3:    k = KEY_W'($urandom);
      default: k = last_key + KEY_W'($urandom_range(1, 20));
    endcase
    len  = ($urandom_range(7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    ends = ($urandom_range(5) == 0);
    for (int unsigned i = 0; i < len; i++)
      send_item(k, pick_value(), ends && (i == len - 1), 1'b0, NO_WANT);
    last_key = k;
  endtask

  task automatic check_field(string fname, logic [30:0] want, logic [30:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
      n_errors++;
    end
  endtask

  // Result side: checks accepted groups, idles at random, holds off once
  initial begin
    grp_result_t exp_r;
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        n_results++;
        if (pending_groups.size() == 0) begin
          $display("%0t: unexpected group: expected none, actual key %h", $time,
                   out_group_key_out);
          n_errors++;
        end else begin
          exp_r = pending_groups.pop_front();
          check_field("group_key", exp_r.key, out_group_key_out);
          check_field("group_max", exp_r.max, out_group_max_out);
          check_field("group_average", exp_r.avg, out_group_average_out);
          check_field("run_last", 31'(exp_r.last), 31'(out_run_last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held_once && n_results == 60) begin
        held_once = 1;
        hold_left = HOLD_LEN;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin
    n_cycles = 0;
    forever begin
      @(posedge clk);
      n_cycles++;
      if (n_cycles > CYCLE_CAP) begin
        $display("timeout after %0d cycles, %0d groups outstanding", n_cycles,
                 pending_groups.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] last_key;
    bit               drained;
    last_key = '0;
    drained  = 0;
    calm     = 0;
    clear_group();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++)
      send_item(dir_tab[i].key, dir_tab[i].val, dir_tab[i].eos, dir_tab[i].typed,
                dir_tab[i].want);

    while (n_items < NDIR + N_RANDOM) begin
      calm = (n_items >= 300 && n_items < 500);
      if (!drained && n_items >= 650) begin
        // let the pipeline run dry before going on
        drained = 1;
        push <= 1'b0;
        @(posedge clk);
        while (pending_groups.size() != 0) @(posedge clk);
      end
      random_group(last_key);
    end
    calm = 0;
    push <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d records in, %0d groups checked, %0d end-of-stream records",
             n_items, n_results, n_eos);
    $display("%0d records closed two groups at once; %0d mismatches", n_double, n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sorted_group_max_average.f
rtl/core/sgma_pkg.sv
rtl/core/sgma_front.sv
rtl/core/sgma_queue.sv
rtl/core/sgma_back.sv
rtl/core/sorted_group_max_average.sv
rtl/core/sgma_checker.sv
test/tb_sorted_group_max_average.sv
